// ----- rtl/mamt_pkg.sv -----
// Shared types and constants of the alarm match table.
package mamt_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_ENABLE = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_FULL         = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND    = 2'd2;
    localparam logic [1:0] ST_TIME_INVALID = 2'd3;

    localparam logic signed [12:0] YEAR_MIN = 13'sd2024;
    localparam logic [12:0] YEAR_NONE  = 13'h1FFF;
    localparam logic [4:0]  MONTH_NONE = 5'h1F;
    localparam logic [5:0]  DAY_NONE   = 6'h3F;
    localparam logic [11:0] NO_TIME    = 12'hFFF;
    localparam logic [15:0] FIRST_ID   = 16'd1;

    typedef struct packed {
        logic [15:0] id;
        logic [5:0]  day;
        logic [4:0]  month;
        logic [12:0] year;
        logic [6:0]  day_mask;
        logic [5:0]  minute;
        logic [4:0]  hour;
    } entry_t;

endpackage

// ----- rtl/mamt_entry_ram.sv -----
// Alarm entry storage: one write port, one registered read port.
module mamt_entry_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  mamt_pkg::entry_t   wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output mamt_pkg::entry_t   rd_data
);
    import mamt_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/multi_alarm_match_table_unit.sv -----
// Alarm match table: add, remove, enable and time tick over a slot memory.
// A request is held through the scan and completion states before its result is registered;
// no new request is accepted until the table is idle again, as the scan reads every slot
// of the entry memory through its single read port.
// Reset (synchronous, active low) empties the table at once via valid bits,
// sets the next id to 1 and forgets the last ringing time; no clearing pass.
module multi_alarm_match_table_unit #(
    parameter int ALARM_SLOTS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_op,
    input  logic [4:0]          s_hour,
    input  logic [5:0]          s_minute,
    input  logic signed [12:0]  s_year,
    input  logic signed [4:0]   s_month,
    input  logic signed [5:0]   s_day,
    input  logic [2:0]          s_weekday,
    input  logic [6:0]          s_day_mask,
    input  logic [15:0]         s_alarm_id,
    input  logic                s_enable_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [15:0]         m_assigned_id,
    output logic                m_ring,
    output logic [4:0]          m_ring_count,
    output logic [4:0]          m_entries_used
);
    import mamt_pkg::*;

    localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam int CNT_W = $clog2(ALARM_SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALARM_SLOTS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    function automatic logic [4:0] sat5(input logic [CNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'd31) ? 5'd31 : w[4:0];
    endfunction

    logic [1:0]              state_reg, state_next;
    logic [ALARM_SLOTS-1:0]  valid_reg;
    logic [ALARM_SLOTS-1:0]  enabled_reg;
    logic [15:0]             next_id_reg;
    logic [11:0]             last_rang_reg;
    logic [CNT_W-1:0]        used_reg, used_next;

    logic [1:0]              req_op_reg;
    logic [4:0]              req_hour_reg;
    logic [5:0]              req_minute_reg;
    logic signed [12:0]      req_year_reg;
    logic signed [4:0]       req_month_reg;
    logic signed [5:0]       req_day_reg;
    logic [2:0]              req_weekday_reg;
    logic [6:0]              req_mask_reg;
    logic [15:0]             req_id_reg;
    logic                    req_en_reg;

    logic [IDX_W-1:0]        issue_idx_reg;
    logic                    issue_on_reg;
    logic                    proc_valid_reg;
    logic [IDX_W-1:0]        proc_idx_reg;
    logic                    found_reg;
    logic [IDX_W-1:0]        slot_reg;
    logic [CNT_W-1:0]        ring_cnt_reg;

    logic                    m_valid_reg;
    logic [1:0]              m_status_reg;
    logic [15:0]             m_assigned_reg;
    logic                    m_ring_reg;
    logic [4:0]              m_ring_count_reg;
    logic [4:0]              m_used_reg;

    logic       rd_en;
    entry_t     rd_data;
    logic       wr_en;
    entry_t     wr_data;
    logic       out_free;
    logic       accept;
    logic       year_ok;
    logic       tick_ok;
    logic [11:0] now;
    logic       cur_valid;
    logic       cur_enabled;
    logic       time_match;
    logic       dated;
    logic       date_match;
    logic [6:0] mask_sh;
    logic       hit;
    logic [1:0] status_c;

    mamt_entry_ram #(
        .DEPTH  (ALARM_SLOTS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (issue_idx_reg),
        .rd_data (rd_data)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign rd_en    = (state_reg == S_SCAN) && issue_on_reg;

    assign now     = {1'b0, req_hour_reg, req_minute_reg};
    assign year_ok = !req_year_reg[12] && (req_year_reg >= YEAR_MIN);
    assign tick_ok = year_ok && (now != last_rang_reg);

    assign cur_valid   = valid_reg[proc_idx_reg];
    assign cur_enabled = enabled_reg[proc_idx_reg];
    assign time_match  = (rd_data.hour == req_hour_reg) && (rd_data.minute == req_minute_reg);
    assign dated       = (rd_data.year != YEAR_NONE) && (rd_data.month != MONTH_NONE)
                         && (rd_data.day != DAY_NONE);
    assign date_match  = (rd_data.year == $unsigned(req_year_reg))
                         && (rd_data.month == $unsigned(req_month_reg))
                         && (rd_data.day == $unsigned(req_day_reg));
    assign mask_sh     = rd_data.day_mask >> req_weekday_reg;
    assign hit         = cur_valid && cur_enabled && time_match
                         && (dated ? date_match : mask_sh[0]);

    assign wr_en = (state_reg == S_DONE) && out_free && (req_op_reg == OP_ADD) && found_reg;

    always_comb begin
        wr_data.id       = next_id_reg;
        wr_data.day      = $unsigned(req_day_reg);
        wr_data.month    = $unsigned(req_month_reg);
        wr_data.year     = $unsigned(req_year_reg);
        wr_data.day_mask = req_mask_reg;
        wr_data.minute   = req_minute_reg;
        wr_data.hour     = req_hour_reg;
    end

    always_comb begin
        used_next = used_reg;
        status_c  = ST_OK;
        case (req_op_reg)
            OP_ADD: begin
                if (found_reg) begin
                    used_next = used_reg + CNT_W'(1);
                end else begin
                    status_c = ST_FULL;
                end
            end
            OP_REMOVE: begin
                if (found_reg) begin
                    used_next = used_reg - CNT_W'(1);
                end else begin
                    status_c = ST_NOT_FOUND;
                end
            end
            OP_ENABLE: begin
                if (!found_reg) begin
                    status_c = ST_NOT_FOUND;
                end
            end
            default: begin
                if (!year_ok) begin
                    status_c = ST_TIME_INVALID;
                end
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!issue_on_reg && proc_valid_reg) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // request hold
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_op_reg      <= s_op;
            req_hour_reg    <= s_hour;
            req_minute_reg  <= s_minute;
            req_year_reg    <= s_year;
            req_month_reg   <= s_month;
            req_day_reg     <= s_day;
            req_weekday_reg <= s_weekday;
            req_mask_reg    <= s_day_mask;
            req_id_reg      <= s_alarm_id;
            req_en_reg      <= s_enable_value;
        end
    end

    // scan control and table state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            enabled_reg    <= '0;
            next_id_reg    <= FIRST_ID;
            last_rang_reg  <= NO_TIME;
            used_reg       <= '0;
            issue_idx_reg  <= '0;
            issue_on_reg   <= 1'b0;
            proc_valid_reg <= 1'b0;
            proc_idx_reg   <= '0;
            found_reg      <= 1'b0;
            slot_reg       <= '0;
            ring_cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        issue_idx_reg  <= '0;
                        issue_on_reg   <= 1'b1;
                        proc_valid_reg <= 1'b0;
                        found_reg      <= 1'b0;
                        ring_cnt_reg   <= '0;
                    end
                end
                S_SCAN: begin
                    proc_valid_reg <= issue_on_reg;
                    proc_idx_reg   <= issue_idx_reg;
                    if (issue_on_reg) begin
                        if (issue_idx_reg == LAST_IDX) begin
                            issue_on_reg <= 1'b0;
                        end else begin
                            issue_idx_reg <= issue_idx_reg + IDX_W'(1);
                        end
                    end
                    if (proc_valid_reg) begin
                        case (req_op_reg)
                            OP_ADD: begin
                                if (!found_reg && !cur_valid) begin
                                    found_reg <= 1'b1;
                                    slot_reg  <= proc_idx_reg;
                                end
                            end
                            OP_REMOVE, OP_ENABLE: begin
                                if (!found_reg && cur_valid && (rd_data.id == req_id_reg)) begin
                                    found_reg <= 1'b1;
                                    slot_reg  <= proc_idx_reg;
                                end
                            end
                            default: begin
                                if (tick_ok && hit) begin
                                    ring_cnt_reg <= ring_cnt_reg + CNT_W'(1);
                                    if (dated) begin
                                        enabled_reg[proc_idx_reg] <= 1'b0;
                                    end
                                end
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        used_reg <= used_next;
                        case (req_op_reg)
                            OP_ADD: begin
                                if (found_reg) begin
                                    valid_reg[slot_reg]   <= 1'b1;
                                    enabled_reg[slot_reg] <= 1'b1;
                                    next_id_reg           <= next_id_reg + 16'd1;
                                end
                            end
                            OP_REMOVE: begin
                                if (found_reg) begin
                                    valid_reg[slot_reg]   <= 1'b0;
                                    enabled_reg[slot_reg] <= 1'b0;
                                end
                            end
                            OP_ENABLE: begin
                                if (found_reg) begin
                                    enabled_reg[slot_reg] <= req_en_reg;
                                end
                            end
                            default: begin
                                if (tick_ok && (ring_cnt_reg != '0)) begin
                                    last_rang_reg <= now;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    issue_on_reg <= 1'b0;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == S_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_DONE) && out_free) begin
            m_status_reg     <= status_c;
            m_assigned_reg   <= ((req_op_reg == OP_ADD) && found_reg) ? next_id_reg : 16'd0;
            m_ring_reg       <= (req_op_reg == OP_TICK) && tick_ok && (ring_cnt_reg != '0);
            m_ring_count_reg <= ((req_op_reg == OP_TICK) && tick_ok) ? sat5(ring_cnt_reg) : 5'd0;
            m_used_reg       <= sat5(used_next);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_assigned_id  = m_assigned_reg;
    assign m_ring         = m_ring_reg;
    assign m_ring_count   = m_ring_count_reg;
    assign m_entries_used = m_used_reg;

    a_result_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the completion step");

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(used_reg) <= ALARM_SLOTS)
        else $error("occupied count exceeds slot count");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> !wr_en)
        else $error("entry memory written during scan");

    a_ring_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ring_reg) |-> (m_status_reg == ST_OK) && (m_ring_count_reg != 5'd0))
        else $error("ring reported without ok status or count");

endmodule

// ----- bench/tb_multi_alarm_match_table_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the alarm match table: request driver, reply monitor, table predictor.
module tb_multi_alarm_match_table_unit;
    import mamt_pkg::*;

    localparam int ALARM_SLOTS = 16;
    localparam int RANDOM_REQUESTS = 500;
    localparam int CALM_TAIL = 60;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [12:0] year;
        logic [4:0]  month;
        logic [5:0]  day;
        logic [2:0]  weekday;
        logic [6:0]  day_mask;
        logic [15:0] alarm_id;
        logic        enable_value;
    } alarm_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] assigned_id;
        logic        ring;
        logic [4:0]  ring_count;
        logic [4:0]  entries_used;
    } alarm_reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = '0;
    logic [4:0]  s_hour = '0;
    logic [5:0]  s_minute = '0;
    logic [12:0] s_year = '0;
    logic [4:0]  s_month = '0;
    logic [5:0]  s_day = '0;
    logic [2:0]  s_weekday = '0;
    logic [6:0]  s_day_mask = '0;
    logic [15:0] s_alarm_id = '0;
    logic        s_enable_value = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [15:0] m_assigned_id;
    logic        m_ring;
    logic [4:0]  m_ring_count;
    logic [4:0]  m_entries_used;

    alarm_req_t   pending_requests[$];
    alarm_reply_t expected_replies[$];
    alarm_req_t   in_flight;
    alarm_req_t   prev_tick;
    alarm_reply_t want;
    logic         have_tick = 1'b0;
    logic         holding = 1'b0;
    logic         wind_down = 1'b0;
    int           send_gap = 0;
    int           reply_stall = 0;
    int           mismatches = 0;

    // table shadow, mirrors the state right after reset
    entry_t       slot_entry[ALARM_SLOTS];
    logic         slot_used[ALARM_SLOTS] = '{default: 1'b0};
    logic         slot_on[ALARM_SLOTS] = '{default: 1'b0};
    logic [15:0]  id_next = FIRST_ID;
    logic [11:0]  last_ring_time = NO_TIME;

    always #1 aclk = ~aclk;

    multi_alarm_match_table_unit #(.ALARM_SLOTS(ALARM_SLOTS)) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_hour(s_hour),
        .s_minute(s_minute),
        .s_year(s_year),
        .s_month(s_month),
        .s_day(s_day),
        .s_weekday(s_weekday),
        .s_day_mask(s_day_mask),
        .s_alarm_id(s_alarm_id),
        .s_enable_value(s_enable_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_assigned_id(m_assigned_id),
        .m_ring(m_ring),
        .m_ring_count(m_ring_count),
        .m_entries_used(m_entries_used)
    );

    function automatic alarm_req_t make_req(logic [1:0] op, logic [4:0] hour, logic [5:0] minute,
                                            logic [12:0] year, logic [4:0] month,
                                            logic [5:0] day, logic [2:0] weekday,
                                            logic [6:0] day_mask, logic [15:0] alarm_id,
                                            logic enable_value);
        alarm_req_t r;
        r = '{op, hour, minute, year, month, day, weekday, day_mask, alarm_id, enable_value};
        return r;
    endfunction

    function automatic void queue_request(alarm_req_t r);
        pending_requests = {pending_requests, r};
    endfunction

    function automatic logic has_date(entry_t e);
        return e.year != YEAR_NONE && e.month != MONTH_NONE && e.day != DAY_NONE;
    endfunction

    function automatic alarm_reply_t alarm_table_step(alarm_req_t r);
        alarm_reply_t rsp;
        int           slot;
        int           rang;
        int           used;
        logic         dated;
        logic         hit;
        logic [11:0]  now;
        rsp = '0;
        slot = -1;
        rang = 0;
        used = 0;
        case (r.op)
            OP_ADD: begin
                for (int i = ALARM_SLOTS - 1; i >= 0; i--)
                    if (!slot_used[i]) slot = i;
                if (slot < 0) begin
                    rsp.status = ST_FULL;
                end else begin
                    slot_entry[slot] = '{id: id_next, day: r.day, month: r.month, year: r.year,
                                         day_mask: r.day_mask, minute: r.minute, hour: r.hour};
                    slot_used[slot] = 1'b1;
                    slot_on[slot] = 1'b1;
                    rsp.assigned_id = id_next;
                    id_next = id_next + 16'd1;
                end
            end
            OP_REMOVE, OP_ENABLE: begin
                for (int i = ALARM_SLOTS - 1; i >= 0; i--)
                    if (slot_used[i] && slot_entry[i].id == r.alarm_id) slot = i;
                if (slot < 0) begin
                    rsp.status = ST_NOT_FOUND;
                end else if (r.op == OP_REMOVE) begin
                    slot_used[slot] = 1'b0;
                    slot_on[slot] = 1'b0;
                end else begin
                    slot_on[slot] = r.enable_value;
                end
            end
            default: begin
                now = {1'b0, r.hour, r.minute};
                if ($signed(r.year) < YEAR_MIN) begin
                    rsp.status = ST_TIME_INVALID;
                end else if (now != last_ring_time) begin
                    for (int i = 0; i < ALARM_SLOTS; i++) begin
                        if (slot_used[i] && slot_on[i] && slot_entry[i].hour == r.hour &&
                            slot_entry[i].minute == r.minute) begin
                            dated = has_date(slot_entry[i]);
                            if (dated)
                                hit = slot_entry[i].year == r.year &&
                                      slot_entry[i].month == r.month &&
                                      slot_entry[i].day == r.day;
                            else
                                hit = |((slot_entry[i].day_mask >> r.weekday) & 7'd1);
                            if (hit) begin
                                rang++;
                                if (dated) slot_on[i] = 1'b0;
                            end
                        end
                    end
                    if (rang > 0) last_ring_time = now;
                    rsp.ring_count = (rang > 31) ? 5'd31 : rang[4:0];
                    rsp.ring = rang != 0;
                end
            end
        endcase
        for (int i = 0; i < ALARM_SLOTS; i++)
            if (slot_used[i]) used++;
        rsp.entries_used = (used > 31) ? 5'd31 : used[4:0];
        return rsp;
    endfunction

    function automatic alarm_req_t random_request();
        alarm_req_t  r;
        logic [63:0] noise;
        int          start;
        int          pick;
        int          roll;
        noise = {$urandom, $urandom};
        r = noise[$bits(alarm_req_t)-1:0];
        if ($urandom_range(0, 99) < 8) return r;
        if (have_tick && $urandom_range(0, 99) < 8) return prev_tick;
        r.hour = 5'($urandom_range(0, 23));
        r.minute = 6'($urandom_range(0, 59));
        r.weekday = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
        r.year = 13'($urandom_range(2024, 2030));
        r.month = 5'($urandom_range(1, 12));
        r.day = 6'($urandom_range(1, 31));
        start = $urandom_range(0, ALARM_SLOTS - 1);
        pick = -1;
        for (int k = 0; k < ALARM_SLOTS; k++)
            if (pick < 0 && slot_used[(start + k) % ALARM_SLOTS]) pick = (start + k) % ALARM_SLOTS;
        roll = $urandom_range(0, 99);
        if (roll < 28) begin
            r.op = OP_ADD;
            case ($urandom_range(0, 5))
                0: r.year = YEAR_NONE;
                1: r.month = MONTH_NONE;
                2: r.day = DAY_NONE;
                3: begin
                    r.year = YEAR_NONE;
                    r.month = MONTH_NONE;
                    r.day = DAY_NONE;
                end
                default: ;
            endcase
        end else if (roll < 58) begin
            r.op = (roll < 43) ? OP_REMOVE : OP_ENABLE;
            if (pick >= 0 && $urandom_range(0, 4) != 0) r.alarm_id = slot_entry[pick].id;
        end else begin
            r.op = OP_TICK;
            if (pick >= 0 && $urandom_range(0, 9) < 7) begin
                r.hour = slot_entry[pick].hour;
                r.minute = slot_entry[pick].minute;
                if (has_date(slot_entry[pick]) && $urandom_range(0, 9) < 7) begin
                    r.year = slot_entry[pick].year;
                    r.month = slot_entry[pick].month;
                    r.day = slot_entry[pick].day;
                end
            end
            if ($urandom_range(0, 99) < 12) r.year = 13'($urandom);
            prev_tick = r;
            have_tick = 1'b1;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned expected_value,
                               input int unsigned actual_value);
        if (expected_value != actual_value) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, expected_value, actual_value);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            holding = 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_replies = {expected_replies, alarm_table_step(in_flight)};
                holding = 1'b0;
                if (!wind_down && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 19);
            end
            if (!holding) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_requests.size() != 0) begin
                    in_flight = pending_requests.pop_front();
                    holding = 1'b1;
                    s_op <= in_flight.op;
                    s_hour <= in_flight.hour;
                    s_minute <= in_flight.minute;
                    s_year <= in_flight.year;
                    s_month <= in_flight.month;
                    s_day <= in_flight.day;
                    s_weekday <= in_flight.weekday;
                    s_day_mask <= in_flight.day_mask;
                    s_alarm_id <= in_flight.alarm_id;
                    s_enable_value <= in_flight.enable_value;
                end
            end
            s_valid <= holding;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            reply_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t ns: reply with none outstanding, expected none, actual %h",
                             $time, {m_status, m_assigned_id, m_ring, m_ring_count,
                                     m_entries_used});
                    mismatches++;
                end else begin
                    want = expected_replies.pop_front();
                    check_field("status", want.status, m_status);
                    check_field("assigned_id", want.assigned_id, m_assigned_id);
                    check_field("ring", want.ring, m_ring);
                    check_field("ring_count", want.ring_count, m_ring_count);
                    check_field("entries_used", want.entries_used, m_entries_used);
                end
            end
            if (reply_stall > 0)
                reply_stall--;
            else if (!wind_down && $urandom_range(0, 7) == 0)
                reply_stall = $urandom_range(1, 19);
            m_ready <= (reply_stall == 0);
        end
    end

    initial begin
        #1000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        queue_request(make_req(OP_TICK, 7, 30, 2023, 3, 15, 5, 0, 0, 0));
        queue_request(make_req(OP_TICK, 0, 0, YEAR_NONE, MONTH_NONE, DAY_NONE,
                               0, 0, 0, 0));
        queue_request(make_req(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 16'd1, 0));
        queue_request(make_req(OP_ENABLE, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 1));
        queue_request(make_req(OP_ADD, 7, 30, YEAR_NONE, MONTH_NONE, DAY_NONE,
                               0, 7'h7F, 0, 0));
        queue_request(make_req(OP_ADD, 7, 30, 2024, 3, 15, 0, 7'h00, 0, 0));
        queue_request(make_req(OP_ADD, 23, 59, YEAR_NONE, 5, 10, 0, 7'h01, 0, 0));
        queue_request(make_req(OP_ADD, 0, 0, 2024, 1, DAY_NONE, 0, 7'h40, 0, 0));
        queue_request(make_req(OP_TICK, 7, 30, 2024, 3, 15, 5, 0, 0, 0));
        queue_request(make_req(OP_TICK, 7, 30, 2024, 3, 15, 5, 0, 0, 0));
        queue_request(make_req(OP_TICK, 23, 59, 2024, 6, 2, 0, 0, 0, 0));
        queue_request(make_req(OP_TICK, 7, 30, 2024, 3, 15, 7, 0, 0, 0));
        queue_request(make_req(OP_ENABLE, 0, 0, 0, 0, 0, 0, 0, 16'd2, 1));
        queue_request(make_req(OP_TICK, 7, 30, 2025, 3, 15, 1, 0, 0, 0));
        queue_request(make_req(OP_ENABLE, 0, 0, 0, 0, 0, 0, 0, 16'd1, 0));
        queue_request(make_req(OP_TICK, 0, 0, 4095, 12, 31, 6, 0, 0, 0));
        queue_request(make_req(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 16'd4, 0));
        queue_request(make_req(OP_ADD, 31, 63, 4095, 15, 31, 0, 7'h55, 0, 0));
        queue_request(make_req(OP_TICK, 31, 63, 4095, 15, 31, 3, 0, 0, 0));
        for (int i = 0; i < 13; i++)
            queue_request(make_req(OP_ADD, 12, 0, YEAR_NONE, MONTH_NONE,
                                   DAY_NONE, 0, 7'h7F, 0, 0));
        queue_request(make_req(OP_TICK, 12, 0, 2024, 7, 4, 4, 0, 0, 0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            while (pending_requests.size() > 1) @(posedge aclk);
            if (n == RANDOM_REQUESTS - CALM_TAIL) wind_down = 1'b1;
            queue_request(random_request());
        end

        while (pending_requests.size() != 0 || holding) @(posedge aclk);
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (3 * ALARM_SLOTS) @(posedge aclk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
